// ===== design/slot_pool_allocator_oldest_reuse_defines.svh =====
// ----------------------------------------------------------------------------
// Slot pool allocator assertion macros
// Shared property macros for the allocator top level.
// ----------------------------------------------------------------------------
`ifndef SLOT_POOL_ALLOCATOR_OLDEST_REUSE_DEFINES_SVH
`define SLOT_POOL_ALLOCATOR_OLDEST_REUSE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Field widths, codes and shared types of the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 6;
  localparam int SLOT_CAP = 32;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_FRESH    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RECYCLED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RELEASED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_cmd_t;

  typedef struct packed {
    logic cand;
    logic rel;
  } cell_hit_t;

endpackage

`default_nettype wire

// ===== design/spa_cell.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator list cell
// One entry of the allocation-order list, oldest entries in the lowest cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spa_cell (
  input  wire                              clk,
  input  spa_pkg::cell_cmd_t               cmd,
  input  wire  [spa_pkg::SLOT_W-1:0]       neighbor_slot,
  input  wire  [spa_pkg::SLOT_W-1:0]       append_slot,
  input  wire                              in_list,
  input  wire  [spa_pkg::SLOT_W-1:0]       req_slot,
  input  wire  [spa_pkg::CFG_W-1:0]        eff_size,
  output logic [spa_pkg::SLOT_W-1:0]       slot,
  output spa_pkg::cell_hit_t               hit
);

  // A load of the tail takes priority over the shift from the younger neighbor.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot <= append_slot;
    end else if (cmd.shift) begin
      slot <= neighbor_slot;
    end
  end

  always_comb begin
    hit.cand = in_list && ({1'b0, slot} < eff_size);
    hit.rel  = in_list && (slot == req_slot);
  end

endmodule

`default_nettype wire

// ===== design/slot_pool_allocator_oldest_reuse.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator with oldest-first reuse
// Grants the lowest free slot, recycles the oldest one when the pool is full, releases slots.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                       Contents
//  s_*       in         s_tvalid s_tready s_tdata     tdata: slot, tuser: operation
//                       s_tuser
//  m_*       out        m_tvalid m_tready m_tdata     tdata: granted_slot, tuser: status
//                       m_tuser
//  cfg_*     in         cfg_valid cfg_ready cfg_data  pool_size
//
//  Each request passes an evaluate state, which evaluates the cell row and the free map,
//  and a commit state, which commits the shift of the list cells and loads the result register.
//  While results are taken, the next request is accepted in that commit state.
//  A result waiting in the output register holds the commit, and a request
//  that follows is only accepted together with that commit.
//  Reset is synchronous and clears the state, the list count and the active map;
//  no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "slot_pool_allocator_oldest_reuse_defines.svh"

module slot_pool_allocator_oldest_reuse #(
  parameter int POOL_DEPTH = 32
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,    // [4:0] slot, [7:5] zero
  input  wire  [0:0] s_tuser,    // [0] operation
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,    // [4:0] granted_slot, [7:5] zero
  output logic [1:0] m_tuser,    // [1:0] status
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [5:0] cfg_data    // [5:0] pool_size
);

  localparam int CAP   = (POOL_DEPTH > spa_pkg::SLOT_CAP) ? spa_pkg::SLOT_CAP : POOL_DEPTH;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam logic [spa_pkg::CFG_W-1:0] CAP_SIZE = spa_pkg::CFG_W'(CAP);

  spa_pkg::state_t state, state_next;

  logic [spa_pkg::CFG_W-1:0]  eff_size;
  logic [CAP-1:0]             active_map;
  logic [CNT_W-1:0]           count;
  logic                       req_op;
  logic [spa_pkg::SLOT_W-1:0] req_slot;

  // Evaluation results, registered for the commit cycle.
  logic [CAP-1:0]               rm_onehot;
  logic                         app_en;
  logic [CAP-1:0]               set_mask;
  logic [CAP-1:0]               clr_mask;
  logic [spa_pkg::STATUS_W-1:0] res_status;
  logic [spa_pkg::SLOT_W-1:0]   res_slot;

  logic s_accept;
  logic commit;

  assign cfg_ready = 1'b1;
  assign s_accept  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    commit     = 1'b0;
    case (state)
      spa_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = spa_pkg::ST_EVAL;
        end
      end
      spa_pkg::ST_EVAL: begin
        state_next = spa_pkg::ST_COMMIT;
      end
      spa_pkg::ST_COMMIT: begin
        if (!m_tvalid || m_tready) begin
          commit     = 1'b1;
          s_tready   = 1'b1;
          state_next = s_tvalid ? spa_pkg::ST_EVAL : spa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spa_pkg::ST_IDLE;
      end
    endcase
  end

  // Pool size is stored already saturated to the usable range.
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_size <= CAP_SIZE;
    end else if (cfg_valid) begin
      if (cfg_data == '0) begin
        eff_size <= spa_pkg::CFG_W'(1);
      end else if (cfg_data > CAP_SIZE) begin
        eff_size <= CAP_SIZE;
      end else begin
        eff_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      req_op   <= s_tuser[0];
      req_slot <= s_tdata[spa_pkg::SLOT_W-1:0];
    end
  end

  // ---------------------------------------------------------------- cell row
  logic [spa_pkg::SLOT_W-1:0] cell_slot [CAP];
  spa_pkg::cell_cmd_t         cell_cmd  [CAP];
  spa_pkg::cell_hit_t         cell_hit  [CAP];
  logic [CAP-1:0]             cand_vec;
  logic [CAP-1:0]             rel_vec;
  logic [CNT_W-1:0]           count_next;
  logic [CNT_W-1:0]           tail;
  logic [CAP-1:0]             at_or_after;
  logic                       rm_any;

  assign rm_any      = |rm_onehot;
  assign at_or_after = ~(rm_onehot - CAP'(1));
  assign count_next  = count - CNT_W'(rm_any) + CNT_W'(app_en);
  assign tail        = count_next - CNT_W'(1);

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [spa_pkg::SLOT_W-1:0] neighbor;

    if (i == CAP - 1) begin : g_last
      assign neighbor = '0;
    end else begin : g_mid
      assign neighbor = cell_slot[i+1];
    end

    always_comb begin
      cell_cmd[i].load  = commit && app_en && (CNT_W'(i) == tail);
      cell_cmd[i].shift = commit && rm_any && at_or_after[i];
    end

    spa_cell u_cell (
      .clk           (clk),
      .cmd           (cell_cmd[i]),
      .neighbor_slot (neighbor),
      .append_slot   (res_slot),
      .in_list       (CNT_W'(i) < count),
      .req_slot      (req_slot),
      .eff_size      (eff_size),
      .slot          (cell_slot[i]),
      .hit           (cell_hit[i])
    );

    assign cand_vec[i] = cell_hit[i].cand;
    assign rel_vec[i]  = cell_hit[i].rel;
  end

  // -------------------------------------------------------------- evaluation
  logic [CAP-1:0]             free_vec;
  logic [CAP-1:0]             free_first;
  logic [CAP-1:0]             cand_first;
  logic [CAP-1:0]             slot_dec;
  logic [spa_pkg::SLOT_W-1:0] free_idx;
  logic [spa_pkg::SLOT_W-1:0] cand_slot;
  logic                       out_range;

  always_comb begin
    free_idx  = '0;
    cand_slot = '0;
    for (int i = 0; i < CAP; i++) begin
      free_vec[i] = !active_map[i] && (spa_pkg::CFG_W'(i) < eff_size);
      slot_dec[i] = (req_slot == spa_pkg::SLOT_W'(i));
    end
    free_first = free_vec & (~free_vec + CAP'(1));
    cand_first = cand_vec & (~cand_vec + CAP'(1));
    for (int i = 0; i < CAP; i++) begin
      if (free_first[i]) begin
        free_idx = free_idx | spa_pkg::SLOT_W'(i);
      end
      if (cand_first[i]) begin
        cand_slot = cand_slot | cell_slot[i];
      end
    end
    out_range = ({1'b0, req_slot} >= eff_size);
  end

  always_ff @(posedge clk) begin
    if (state == spa_pkg::ST_EVAL) begin
      rm_onehot <= '0;
      app_en    <= 1'b0;
      set_mask  <= '0;
      clr_mask  <= '0;
      res_slot  <= '0;
      if (req_op == spa_pkg::OP_ALLOC) begin
        if (|free_vec) begin
          res_status <= spa_pkg::STATUS_FRESH;
          res_slot   <= free_idx;
          set_mask   <= free_first;
          app_en     <= 1'b1;
        end else begin
          // Oldest in-pool entry moves to the tail; with none it answers slot 0.
          res_status <= spa_pkg::STATUS_RECYCLED;
          res_slot   <= cand_slot;
          rm_onehot  <= cand_first;
          app_en     <= |cand_vec;
        end
      end else if (out_range) begin
        res_status <= spa_pkg::STATUS_IGNORED;
      end else begin
        res_status <= spa_pkg::STATUS_RELEASED;
        rm_onehot  <= rel_vec;
        clr_mask   <= slot_dec;
      end
    end
  end

  // ------------------------------------------------------------------ commit
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      active_map <= '0;
    end else if (commit) begin
      count      <= count_next;
      active_map <= (active_map | set_mask) & ~clr_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {{(8 - spa_pkg::SLOT_W){1'b0}}, res_slot};
      m_tuser <= res_status;
    end
  end

  // -------------------------------------------------------------- assertions
  `SPA_ASSERT_IMPL(a_list_matches_map, 1'b1, $countones(active_map) == 32'(count), "active map and list count disagree")
  `SPA_ASSERT_IMPL(a_release_unique, state == spa_pkg::ST_EVAL, $onehot0(rel_vec), "slot appears twice in the order list")
  `SPA_ASSERT_NEXT(a_commit_result, commit, m_tvalid, "committed beat did not reach the output register")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot pool allocator testbench
// Drives allocate and release requests through the request stream under
// several pool sizes, with random gaps on the request side and random stalls
// on the result side. A scoreboard keeps its own free map and allocation-order
// list, predicts every result and compares it with what the block returns.
// ----------------------------------------------------------------------------

module tb;

  localparam int POOL_DEPTH  = 32;
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASES      = 17;
  localparam int PHASE_ITEMS = 100;
  localparam int MAX_WAIT    = 18;

  class slot_scoreboard;
    typedef struct packed {
      logic [spa_pkg::STATUS_W-1:0] status;
      logic [spa_pkg::SLOT_W-1:0]   slot;
    } grant_t;

    logic [spa_pkg::CFG_W-1:0]    pool_size;
    logic [spa_pkg::SLOT_CAP-1:0] active_map;
    logic [spa_pkg::SLOT_W-1:0]   order_q[$];
    grant_t                       grant_q[$];
    int                           errors;
    int                           printed;

    function new();
      pool_size  = 6'd32;
      active_map = '0;
      errors     = 0;
      printed    = 0;
    endfunction

    function int usable_slots();
      int lim;
      int s;
      lim = (POOL_DEPTH < spa_pkg::SLOT_CAP) ? POOL_DEPTH : spa_pkg::SLOT_CAP;
      s = int'(pool_size);
      if (s > lim) s = lim;
      if (s < 1) s = 1;
      return s;
    endfunction

    function int pending();
      return grant_q.size();
    endfunction

    // Works out the result of one accepted request and updates the pool.
    function void note_request(logic op, logic [spa_pkg::SLOT_W-1:0] slot);
      grant_t g;
      int     size;
      bit     done;
      size = usable_slots();
      done = 0;
      if (op == spa_pkg::OP_ALLOC) begin
        for (int i = 0; i < size && !done; i++) begin
          if (!active_map[i]) begin
            active_map[i] = 1'b1;
            order_q.push_back(i[spa_pkg::SLOT_W-1:0]);
            g.status = spa_pkg::STATUS_FRESH;
            g.slot   = i[spa_pkg::SLOT_W-1:0];
            done     = 1;
          end
        end
        // Pool full: the oldest entry below the size goes to the tail again.
        // Slots left active above a shrunk size are skipped.
        for (int i = 0; i < order_q.size() && !done; i++) begin
          if (int'(order_q[i]) < size) begin
            g.status = spa_pkg::STATUS_RECYCLED;
            g.slot   = order_q[i];
            order_q.delete(i);
            order_q.push_back(g.slot);
            done = 1;
          end
        end
        if (!done) begin
          g.status = spa_pkg::STATUS_RECYCLED;
          g.slot   = '0;
        end
      end else begin
        g.slot = '0;
        if (int'(slot) >= size) begin
          g.status = spa_pkg::STATUS_IGNORED;
        end else begin
          for (int i = 0; i < order_q.size() && !done; i++) begin
            if (order_q[i] == slot) begin
              order_q.delete(i);
              done = 1;
            end
          end
          active_map[slot] = 1'b0;
          g.status = spa_pkg::STATUS_RELEASED;
        end
      end
      grant_q.push_back(g);
    endfunction

    task report(string msg);
      errors++;
      if (printed < 100) begin
        printed++;
        $display("%0t ns: mismatch: %s", $time, msg);
      end
    endtask

    task check_result(logic [spa_pkg::STATUS_W-1:0] status, logic [7:0] data);
      grant_t want;
      if (grant_q.size() == 0) begin
        report($sformatf("result with nothing outstanding, status %0d data %0d",
                         status, data));
        return;
      end
      want = grant_q.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, predicted %0d", status, want.status));
      if (data !== {3'b000, want.slot})
        report($sformatf("granted slot field %0d, predicted %0d", data, want.slot));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  wire        s_tready;
  logic [7:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  wire        m_tvalid;
  logic       m_tready = 1'b0;
  wire  [7:0] m_tdata;
  wire  [1:0] m_tuser;
  logic       cfg_valid = 1'b0;
  wire        cfg_ready;
  logic [5:0] cfg_data = '0;

  slot_scoreboard board = new();
  bit src_burst  = 0;
  bit sink_burst = 0;

  slot_pool_allocator_oldest_reuse #(
    .POOL_DEPTH(POOL_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [4:0] slot, [7:5] zero
    .s_tuser  (s_tuser),    // [0] operation
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [4:0] granted_slot, [7:5] zero
    .m_tuser  (m_tuser),    // [1:0] status
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)    // [5:0] pool_size
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Sends one request beat. The valid is left high after acceptance so that a
  // back-to-back beat does not drop it for a cycle.
  task automatic send_request(input logic op, input logic [spa_pkg::SLOT_W-1:0] slot);
    int gap;
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {3'b000, 5'($urandom)};
      s_tuser  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, slot};
    s_tuser  <= op;
    do @(posedge clk); while (s_tready !== 1'b1);
    board.note_request(op, slot);
  endtask

  task automatic send_alloc();
    send_request(spa_pkg::OP_ALLOC, 5'($urandom));
  endtask

  // Pool size writes happen only with nothing in flight.
  task automatic set_pool_size(input logic [spa_pkg::CFG_W-1:0] value);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    board.pool_size = value;
  endtask

  // Mostly a slot that is currently held, sometimes any slot at all.
  function automatic logic [spa_pkg::SLOT_W-1:0] release_target();
    logic [spa_pkg::SLOT_W-1:0] held[$];
    for (int i = 0; i < spa_pkg::SLOT_CAP; i++)
      if (board.active_map[i]) held.push_back(i[spa_pkg::SLOT_W-1:0]);
    if (held.size() == 0 || $urandom_range(0, 3) == 0) return 5'($urandom);
    return held[$urandom_range(0, held.size() - 1)];
  endfunction

  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1 || m_tready !== 1'b1);
      board.check_result(m_tuser, m_tdata);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int fixed_sizes[9] = '{32, 1, 0, 63, 2, 33, 31, 16, 5};
    int alloc_pct;
    int size_pick;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, starting from the reset pool size.
    send_request(spa_pkg::OP_RELEASE, 5'd0);     // release of a slot that is not held
    send_request(spa_pkg::OP_RELEASE, 5'd31);
    send_alloc();
    send_alloc();
    send_alloc();
    send_request(spa_pkg::OP_RELEASE, 5'd1);
    send_alloc();                                // lowest free slot comes back
    // Shrink below a held slot: slot 2 stays held but is never recycled.
    set_pool_size(6'd2);
    send_alloc();
    send_alloc();
    send_request(spa_pkg::OP_RELEASE, 5'd2);     // outside the pool now
    send_request(spa_pkg::OP_RELEASE, 5'd31);
    set_pool_size(6'd0);                         // behaves as a pool of one
    send_alloc();
    send_request(spa_pkg::OP_RELEASE, 5'd1);
    send_request(spa_pkg::OP_RELEASE, 5'd0);
    send_alloc();
    set_pool_size(6'd63);                        // saturates to the full pool
    send_alloc();
    send_alloc();
    send_request(spa_pkg::OP_RELEASE, 5'd31);
    send_request(spa_pkg::OP_RELEASE, 5'd2);
    set_pool_size(6'd1);
    send_alloc();
    send_alloc();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 9) begin
        size_pick = fixed_sizes[p];
      end else if ($urandom_range(0, 3) == 0) begin
        size_pick = $urandom_range(0, 63);
      end else begin
        size_pick = $urandom_range(1, 8);
      end
      set_pool_size(6'(size_pick));
      case ($urandom_range(0, 3))
        0: alloc_pct = 25;
        1: alloc_pct = 50;
        2: alloc_pct = 75;
        default: alloc_pct = 95;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(1, 100) <= alloc_pct) begin
          send_alloc();
        end else begin
          send_request(spa_pkg::OP_RELEASE, release_target());
        end
      end
    end

    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.pending() != 0) board.report("results still outstanding at the end");
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
